FILE: rtl/lmfp_pkg.sv
`default_nettype none

package lmfp_pkg;

   localparam int MAX_LIGHTS_DEF = 64;
   localparam int LIGHT_W        = 6;
   localparam int COUNT_W        = 7;
   localparam int MODE_W         = 3;
   localparam int PERIOD_W       = 16;
   localparam int TIME_W         = 32;
   localparam int BYTE_SLOTS     = 8;
   localparam int BYTE_IDX_W     = 3;
   localparam int DIV_STEP_W     = $clog2(TIME_W);
   localparam int CSR_IDX_W      = 2;

   localparam logic [1:0] CMD_SET_ONE = 2'd0;
   localparam logic [1:0] CMD_SET_ALL = 2'd1;
   localparam logic [1:0] CMD_UPDATE  = 2'd2;

   localparam logic [MODE_W-1:0] MODE_ON   = 3'd1;
   localparam logic [MODE_W-1:0] MODE_FAST = 3'd2;
   localparam logic [MODE_W-1:0] MODE_SLOW = 3'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_FAST_PERIOD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLOW_PERIOD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LIGHT_COUNT = 2'd2;

   localparam logic [PERIOD_W-1:0] FAST_PERIOD_RST = 16'd250;
   localparam logic [PERIOD_W-1:0] SLOW_PERIOD_RST = 16'd1000;
   localparam logic [COUNT_W-1:0]  LIGHT_COUNT_RST = 7'd32;

   typedef struct packed {
      logic                we;
      logic                re;
      logic [LIGHT_W-1:0]  addr;
      logic [MODE_W-1:0]   wdata;
   } lmfp_mem_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [PERIOD_W-1:0] rem;
   } lmfp_div_rsp_type;

endpackage

`default_nettype wire

FILE: rtl/lmfp_mod_unit.sv
`default_nettype none

module lmfp_mod_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [lmfp_pkg::TIME_W-1:0]   dividend,
   input  wire logic [lmfp_pkg::PERIOD_W-1:0] divisor,
   output lmfp_pkg::lmfp_div_rsp_type         div_rsp
);
   import lmfp_pkg::*;

   logic                  run_ff;
   logic                  done_ff;
   logic [DIV_STEP_W-1:0] step_ff;
   logic [TIME_W-1:0]     num_ff;
   logic [PERIOD_W-1:0]   den_ff;
   logic [PERIOD_W-1:0]   rem_ff;

   logic [PERIOD_W:0]     trial;
   logic [PERIOD_W:0]     diff;
   logic [PERIOD_W-1:0]   rem_in;
   logic                  last_step;

   // one restoring step: bring down the next dividend bit, subtract if it fits
   assign trial     = {rem_ff, num_ff[TIME_W-1]};
   assign diff      = trial - {1'b0, den_ff};
   assign rem_in    = (trial >= {1'b0, den_ff}) ? diff[PERIOD_W-1:0] : trial[PERIOD_W-1:0];
   assign last_step = (step_ff == DIV_STEP_W'(TIME_W - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff  <= 1'b1;
            step_ff <= '0;
         end else if (run_ff) begin
            step_ff <= step_ff + 1'b1;
            if (last_step) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= dividend;
         den_ff <= divisor;
         rem_ff <= '0;
      end else if (run_ff) begin
         num_ff <= {num_ff[TIME_W-2:0], 1'b0};
         rem_ff <= rem_in;
      end
   end

   assign div_rsp.busy = run_ff;
   assign div_rsp.done = done_ff;
   assign div_rsp.rem  = rem_ff;

endmodule

`default_nettype wire

FILE: rtl/lmfp_mode_mem.sv
`default_nettype none

module lmfp_mode_mem #(
   parameter int SLOTS = lmfp_pkg::MAX_LIGHTS_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  lmfp_pkg::lmfp_mem_req_type       mem_req,
   output logic [lmfp_pkg::MODE_W-1:0]      rd_mode
);
   import lmfp_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);

   logic [MODE_W-1:0] mem [SLOTS];
   logic [SLOTS-1:0]  valid_ff;
   logic [MODE_W-1:0] rd_mode_ff;
   logic [IDX_W-1:0]  idx;

   assign idx = mem_req.addr[IDX_W-1:0];

   // an entry never written reads as off
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (mem_req.we) begin
         valid_ff[idx] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[idx] <= mem_req.wdata;
      end
      if (mem_req.re) begin
         rd_mode_ff <= valid_ff[idx] ? mem[idx] : '0;
      end
   end

   assign rd_mode = rd_mode_ff;

endmodule

`default_nettype wire

FILE: rtl/light_mode_flasher_packer.sv
// Light mode table and flasher packer. Each command takes start while busy is low;
// set-one writes its light straight from idle, set-all walks the lights at one per
// cycle, and an update makes two 32-step modulo runs on the single shared remainder
// unit, then reads each light through the mode memory's registered read port and, if
// any packed byte changed, emits one word per cycle. Words appear on
// the rsp_ ports for exactly one cycle each, marked by rsp_strobe, highest byte first;
// the receiver cannot stall them, so it must take every strobed word as it comes.
// Configuration writes are always ready and are meant for when the block is idle.
`default_nettype none

module light_mode_flasher_packer #(
   parameter int MAX_LIGHTS = lmfp_pkg::MAX_LIGHTS_DEF
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   output logic                                 busy,
   input  wire logic [1:0]                      req_cmd,
   input  wire logic [lmfp_pkg::LIGHT_W-1:0]    req_light_index,
   input  wire logic [lmfp_pkg::MODE_W-1:0]     req_mode,
   input  wire logic [lmfp_pkg::TIME_W-1:0]     req_now_ms,
   output logic                                 rsp_strobe,
   output logic [7:0]                           rsp_out_byte,
   output logic [lmfp_pkg::BYTE_IDX_W-1:0]      rsp_byte_index,
   output logic                                 rsp_last,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [lmfp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lmfp_pkg::PERIOD_W-1:0]   csr_wdata
);
   import lmfp_pkg::*;

   localparam int LIGHT_SLOTS = (MAX_LIGHTS < BYTE_SLOTS * 8) ? MAX_LIGHTS : BYTE_SLOTS * 8;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FILL,
      ST_DIV_FAST,
      ST_DIV_SLOW,
      ST_PACK_RD,
      ST_PACK_ACC,
      ST_EMIT
   } state_type;

   function automatic logic flash_lit(input logic [PERIOD_W-1:0] rem,
                                      input logic [PERIOD_W-1:0] period);
      flash_lit = (period >= 16'd2) && (rem < {1'b0, period[PERIOD_W-1:1]});
   endfunction

   state_type              state_ff, state_in;
   logic [LIGHT_W-1:0]     light_ff, light_in;
   logic [MODE_W-1:0]      fill_mode_ff, fill_mode_in;
   logic [TIME_W-1:0]      now_ff, now_in;
   logic                   fast_lit_ff, fast_lit_in;
   logic                   slow_lit_ff, slow_lit_in;
   logic [7:0]             acc_ff, acc_in;
   logic                   changed_ff, changed_in;
   logic [BYTE_IDX_W-1:0]  emit_ff, emit_in;
   logic                   div_start_ff, div_start_in;
   logic                   rsp_strobe_ff, rsp_strobe_in;
   logic [7:0]             rsp_byte_ff, rsp_byte_in;
   logic [BYTE_IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic [PERIOD_W-1:0]    fast_period_ff;
   logic [PERIOD_W-1:0]    slow_period_ff;
   logic [COUNT_W-1:0]     light_count_ff;

   logic [7:0]             packed_ff [BYTE_SLOTS];
   logic [BYTE_IDX_W-1:0]  pk_sel;
   logic [7:0]             pk_rd;
   logic                   pk_we;

   logic [COUNT_W-1:0]     count_eff;
   logic                   accept;
   logic                   last_light;
   logic                   byte_end;
   logic                   lit;
   logic [7:0]             acc_next;
   logic                   changed_next;
   logic [MODE_W-1:0]      rd_mode;
   logic [PERIOD_W-1:0]    div_divisor;

   lmfp_mem_req_type       mem_req;
   lmfp_div_rsp_type       div_rsp;

   lmfp_mode_mem #(
      .SLOTS (LIGHT_SLOTS)
   ) u_mode_mem (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_mode (rd_mode)
   );

   lmfp_mod_unit u_mod_unit (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (now_ff),
      .divisor  (div_divisor),
      .div_rsp  (div_rsp)
   );

   assign count_eff   = (light_count_ff > COUNT_W'(LIGHT_SLOTS)) ? COUNT_W'(LIGHT_SLOTS)
                                                                 : light_count_ff;
   assign accept      = start && (state_ff == ST_IDLE);
   assign busy        = (state_ff != ST_IDLE);
   assign last_light  = ({1'b0, light_ff} == (count_eff - 1'b1));
   assign byte_end    = (light_ff[2:0] == 3'd7) || last_light;
   assign lit         = (rd_mode == MODE_ON) || ((rd_mode == MODE_FAST) && fast_lit_ff) ||
                        ((rd_mode == MODE_SLOW) && slow_lit_ff);
   // the first light of a byte starts afresh and ends up in the MSB of a full byte
   assign acc_next    = {((light_ff[2:0] == 3'd0) ? 7'd0 : acc_ff[6:0]), lit};
   assign div_divisor = (state_ff == ST_DIV_SLOW) ? slow_period_ff : fast_period_ff;
   assign pk_sel      = (state_ff == ST_EMIT) ? emit_ff : light_ff[LIGHT_W-1:3];
   assign pk_rd       = packed_ff[pk_sel];

   always_comb begin
      state_in      = state_ff;
      light_in      = light_ff;
      fill_mode_in  = fill_mode_ff;
      now_in        = now_ff;
      fast_lit_in   = fast_lit_ff;
      slow_lit_in   = slow_lit_ff;
      acc_in        = acc_ff;
      changed_in    = changed_ff;
      changed_next  = changed_ff;
      emit_in       = emit_ff;
      div_start_in  = 1'b0;
      rsp_strobe_in = 1'b0;
      rsp_byte_in   = rsp_byte_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_last_in   = rsp_last_ff;
      pk_we         = 1'b0;
      mem_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_cmd)
                  CMD_SET_ONE: begin
                     if ({1'b0, req_light_index} < count_eff) begin
                        mem_req.we    = 1'b1;
                        mem_req.addr  = req_light_index;
                        mem_req.wdata = req_mode;
                     end
                  end
                  CMD_SET_ALL: begin
                     if (count_eff != '0) begin
                        fill_mode_in = req_mode;
                        light_in     = '0;
                        state_in     = ST_FILL;
                     end
                  end
                  CMD_UPDATE: begin
                     now_in       = req_now_ms;
                     div_start_in = 1'b1;
                     state_in     = ST_DIV_FAST;
                  end
                  default: ;
               endcase
            end
         end
         ST_FILL: begin
            mem_req.we    = 1'b1;
            mem_req.addr  = light_ff;
            mem_req.wdata = fill_mode_ff;
            if (last_light) begin
               state_in = ST_IDLE;
            end else begin
               light_in = light_ff + 1'b1;
            end
         end
         ST_DIV_FAST: begin
            if (div_rsp.done) begin
               fast_lit_in  = flash_lit(div_rsp.rem, fast_period_ff);
               div_start_in = 1'b1;
               state_in     = ST_DIV_SLOW;
            end
         end
         ST_DIV_SLOW: begin
            if (div_rsp.done) begin
               slow_lit_in = flash_lit(div_rsp.rem, slow_period_ff);
               light_in    = '0;
               changed_in  = 1'b0;
               state_in    = (count_eff == '0) ? ST_IDLE : ST_PACK_RD;
            end
         end
         ST_PACK_RD: begin
            mem_req.re   = 1'b1;
            mem_req.addr = light_ff;
            state_in     = ST_PACK_ACC;
         end
         ST_PACK_ACC: begin
            acc_in = acc_next;
            if (byte_end) begin
               pk_we = 1'b1;
               if (pk_rd != acc_next) begin
                  changed_next = 1'b1;
               end
            end
            changed_in = changed_next;
            if (last_light) begin
               emit_in  = light_ff[LIGHT_W-1:3];
               state_in = changed_next ? ST_EMIT : ST_IDLE;
            end else begin
               light_in = light_ff + 1'b1;
               state_in = ST_PACK_RD;
            end
         end
         ST_EMIT: begin
            rsp_strobe_in = 1'b1;
            rsp_byte_in   = pk_rd;
            rsp_idx_in    = emit_ff;
            rsp_last_in   = (emit_ff == '0);
            if (emit_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               emit_in = emit_ff - 1'b1;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         div_start_ff  <= 1'b0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         div_start_ff  <= div_start_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      light_ff     <= light_in;
      fill_mode_ff <= fill_mode_in;
      now_ff       <= now_in;
      fast_lit_ff  <= fast_lit_in;
      slow_lit_ff  <= slow_lit_in;
      acc_ff       <= acc_in;
      changed_ff   <= changed_in;
      emit_ff      <= emit_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_last_ff  <= rsp_last_in;
   end

   // packed copy of the last update, one byte per slot
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int b = 0; b < BYTE_SLOTS; b++) begin
            packed_ff[b] <= '0;
         end
      end else if (pk_we) begin
         packed_ff[pk_sel] <= acc_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fast_period_ff <= FAST_PERIOD_RST;
         slow_period_ff <= SLOW_PERIOD_RST;
         light_count_ff <= LIGHT_COUNT_RST;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_FAST_PERIOD: fast_period_ff <= csr_wdata;
            CSR_SLOW_PERIOD: slow_period_ff <= csr_wdata;
            CSR_LIGHT_COUNT: light_count_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign csr_ready      = 1'b1;
   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_byte_index = rsp_idx_ff;
   assign rsp_last       = rsp_last_ff;

   a_strobe_from_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe_ff |-> ($past(state_ff) == ST_EMIT))
      else $error("word strobed outside the emit phase");

   a_emit_descends: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe_ff && !rsp_last_ff) |=>
         (rsp_strobe_ff && (rsp_idx_ff == $past(rsp_idx_ff) - 1'b1)))
      else $error("emitted byte run broken or out of order");

   a_mod_unit_private: assert property (@(posedge clock) disable iff (reset)
      div_rsp.busy |-> ((state_ff == ST_DIV_FAST) || (state_ff == ST_DIV_SLOW)))
      else $error("remainder unit running outside its phases");

   a_mem_write_phase: assert property (@(posedge clock) disable iff (reset)
      mem_req.we |-> ((state_ff == ST_IDLE) || (state_ff == ST_FILL)))
      else $error("mode table written during an update");

endmodule

`default_nettype wire
